[hdl/fupc_pkg.sv]
// shared types, constants and character helpers for the form-url percent codec
// no dependencies
package fupc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [4:0] HEX_INVALID = 5'd16;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PCT_THEN,
    KIND_ESCAPE,
    KIND_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  function automatic logic passes_plain(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                      8'h2D, 8'h5F, 8'h2E, 8'h7E});
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_INVALID;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    return v;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) d = CHAR_ZERO + {4'd0, v};
    else d = CHAR_UPPER_A + {4'd0, v - 4'd10};
    return d;
  endfunction

  function automatic logic [7:0] plus_to_space(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

[hdl/form_url_percent_codec_unit.sv]
// Form-url percent codec, one string per tlast-delimited run. cfg_wdata selects
// encode (0) or decode (1); a write also drops any partly decoded escape. Input
// bytes are accepted every cycle while the command queue has room; each output
// byte goes through the registered output, so an input that encodes to a
// three-byte escape holds the single-byte output port for all three bytes,
// and sustained encoding of such bytes is limited by that port.
// Single-result items flow at one per cycle while m_tready is not held low; the
// first result passes through the command queue and then the output register.
// m_tuser flags a bad escape in decode mode.
// depends on fupc_pkg, fupc_front, fupc_queue, fupc_back
module form_url_percent_codec_unit #(
  parameter int QUEUE_DEPTH = fupc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,    // direction
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // out_byte
  output logic       m_tlast,
  output logic       m_tuser       // error
);

  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  fupc_pkg::cmd_t push_cmd;
  fupc_pkg::cmd_t head;

  fupc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  fupc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  fupc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[hdl/fupc_front.sv]
// front end: accepts input bytes, tracks escape and discard state, classifies into commands
// depends on fupc_pkg
module fupc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          queue_full,
  output logic          push,
  output fupc_pkg::cmd_t cmd
);

  logic       direction;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_byte;
  logic [7:0] held_byte_next;
  logic       discarding;
  logic       discarding_next;
  logic       produce;
  logic       accept;
  logic [4:0] hi;
  logic [4:0] lo;

  assign in_ready = !queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && produce;
  assign hi       = fupc_pkg::hex_value(held_byte);
  assign lo       = fupc_pkg::hex_value(in_byte);

  always_comb begin
    produce         = 1'b0;
    cmd.kind        = fupc_pkg::KIND_PLAIN;
    cmd.data        = in_byte;
    cmd.last        = in_last;
    held_count_next = held_count;
    held_byte_next  = held_byte;
    discarding_next = discarding;
    if (!direction) begin
      produce = 1'b1;
      if (fupc_pkg::passes_plain(in_byte)) begin
        cmd.kind = fupc_pkg::KIND_PLAIN;
      end else if (in_byte == fupc_pkg::CHAR_SPACE) begin
        cmd.data = fupc_pkg::CHAR_PLUS;
      end else begin
        cmd.kind = fupc_pkg::KIND_ESCAPE;
      end
    end else if (discarding) begin
      if (in_last) discarding_next = 1'b0;
    end else begin
      case (held_count)
        2'd0: begin
          if (in_byte == fupc_pkg::CHAR_PCT) begin
            if (in_last) begin
              produce = 1'b1;
            end else begin
              held_count_next = 2'd1;
            end
          end else begin
            produce  = 1'b1;
            cmd.data = fupc_pkg::plus_to_space(in_byte);
          end
        end
        2'd1: begin
          if (in_last) begin
            produce         = 1'b1;
            held_count_next = 2'd0;
            cmd.kind        = fupc_pkg::KIND_PCT_THEN;
            cmd.data        = fupc_pkg::plus_to_space(in_byte);
          end else begin
            held_byte_next  = in_byte;
            held_count_next = 2'd2;
          end
        end
        default: begin
          produce         = 1'b1;
          held_count_next = 2'd0;
          held_byte_next  = 8'd0;
          if (hi != fupc_pkg::HEX_INVALID && lo != fupc_pkg::HEX_INVALID) begin
            cmd.data = {hi[3:0], lo[3:0]};
          end else begin
            cmd.kind = fupc_pkg::KIND_ERROR;
            cmd.data = 8'd0;
            cmd.last = 1'b1;
            if (!in_last) discarding_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      held_count <= 2'd0;
      held_byte  <= 8'd0;
      discarding <= 1'b0;
    end else if (cfg_wen) begin
      direction  <= cfg_wdata;
      held_count <= 2'd0;
      held_byte  <= 8'd0;
      discarding <= 1'b0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_byte  <= held_byte_next;
      discarding <= discarding_next;
    end
  end

endmodule

[hdl/fupc_queue.sv]
// command queue between front and back end
// depends on fupc_pkg
module fupc_queue #(
  parameter int DEPTH = fupc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fupc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output fupc_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fupc_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hdl/fupc_back.sv]
// back end: expands queued commands into output bytes through the output register
// depends on fupc_pkg
module fupc_back (
  input  logic           clk,
  input  logic           rst,
  input  fupc_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic           m_tuser
);

  logic [1:0] step;
  logic [1:0] final_step;
  logic       load;
  logic [7:0] byte_next;
  logic       last_next;
  logic       err_next;

  assign load = !empty && (!m_tvalid || m_tready);
  assign pop  = load && (step == final_step);

  always_comb begin
    final_step = 2'd0;
    byte_next  = head.data;
    last_next  = head.last;
    err_next   = 1'b0;
    case (head.kind)
      fupc_pkg::KIND_PLAIN: begin
        final_step = 2'd0;
      end
      fupc_pkg::KIND_PCT_THEN: begin
        final_step = 2'd1;
        if (step == 2'd0) begin
          byte_next = fupc_pkg::CHAR_PCT;
          last_next = 1'b0;
        end
      end
      fupc_pkg::KIND_ESCAPE: begin
        final_step = 2'd2;
        if (step == 2'd0) begin
          byte_next = fupc_pkg::CHAR_PCT;
          last_next = 1'b0;
        end else if (step == 2'd1) begin
          byte_next = fupc_pkg::hex_digit(head.data[7:4]);
          last_next = 1'b0;
        end else begin
          byte_next = fupc_pkg::hex_digit(head.data[3:0]);
        end
      end
      fupc_pkg::KIND_ERROR: begin
        final_step = 2'd0;
        byte_next  = 8'd0;
        last_next  = 1'b1;
        err_next   = 1'b1;
      end
      default: begin
        final_step = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        step     <= (step == final_step) ? 2'd0 : step + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_next;
      m_tlast <= last_next;
      m_tuser <= err_next;
    end
  end

endmodule

[verif/tb_form_url_percent_codec_unit.sv]
// testbench for form_url_percent_codec_unit: directed and random byte strings in both
// directions, results checked against an in-bench model of the encoder and decoder
// depends on fupc_pkg and the rtl of form_url_percent_codec_unit
`timescale 1ns / 100ps

module tb_form_url_percent_codec_unit;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  localparam int QUIET_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_SLOW
  } ready_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // in_byte
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // out_byte
  logic       m_tlast;
  logic       m_tuser;           // error

  // model state
  logic       codec_dir = DIR_ENCODE;
  logic [1:0] held_cnt = 2'd0;
  logic [7:0] held_chr = 8'h00;
  logic       skipping = 1'b0;

  codec_result_t expected_out[$];
  codec_result_t oldest;
  int          mismatches = 0;
  int          useful_items = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic        sender_bursty = 1'b0;
  ready_mode_t ready_mode = READY_ALWAYS;

  form_url_percent_codec_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  function automatic logic is_unreserved(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) ||
           (c >= fupc_pkg::CHAR_ZERO && c <= CH_NINE) ||
           c == CH_DASH || c == CH_UNDER || c == CH_DOT || c == CH_TILDE;
  endfunction

  function automatic logic [4:0] nibble_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= fupc_pkg::CHAR_ZERO && c <= CH_NINE) return {1'b0, c[3:0]};
    if (folded >= CH_LOWER_A && folded <= CH_LOWER_F) return {1'b0, 4'(folded[3:0] + 4'd9)};
    return fupc_pkg::HEX_INVALID;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n > 4'd9) ? fupc_pkg::CHAR_UPPER_A + 8'(n) - 8'd10 : fupc_pkg::CHAR_ZERO + 8'(n);
  endfunction

  function automatic logic [7:0] decoded_char(input logic [7:0] c);
    return (c == fupc_pkg::CHAR_PLUS) ? fupc_pkg::CHAR_SPACE : c;
  endfunction

  function automatic void expect_out(input logic [7:0] d, input logic l, input logic e);
    codec_result_t r;
    r.data = d;
    r.last = l;
    r.err  = e;
    expected_out = {expected_out, r};
  endfunction

  task automatic predict_conversion(input logic [7:0] b, input logic l);
    logic [4:0] hi;
    logic [4:0] lo;
    if (codec_dir == DIR_ENCODE) begin
      useful_items++;
      if (is_unreserved(b)) expect_out(b, l, 1'b0);
      else if (b == fupc_pkg::CHAR_SPACE) expect_out(fupc_pkg::CHAR_PLUS, l, 1'b0);
      else begin
        expect_out(fupc_pkg::CHAR_PCT, 1'b0, 1'b0);
        expect_out(hex_char(b[7:4]), 1'b0, 1'b0);
        expect_out(hex_char(b[3:0]), l, 1'b0);
      end
    end else if (skipping) begin
      if (l) skipping = 1'b0;
    end else begin
      useful_items++;
      case (held_cnt)
        2'd0: begin
          if (b != fupc_pkg::CHAR_PCT) expect_out(decoded_char(b), l, 1'b0);
          else if (l) expect_out(fupc_pkg::CHAR_PCT, 1'b1, 1'b0);
          else held_cnt = 2'd1;
        end
        2'd1: begin
          if (l) begin
            held_cnt = 2'd0;
            expect_out(fupc_pkg::CHAR_PCT, 1'b0, 1'b0);
            expect_out(decoded_char(b), 1'b1, 1'b0);
          end else begin
            held_chr = b;
            held_cnt = 2'd2;
          end
        end
        default: begin
          hi = nibble_value(held_chr);
          lo = nibble_value(b);
          held_cnt = 2'd0;
          held_chr = 8'h00;
          if (hi != fupc_pkg::HEX_INVALID && lo != fupc_pkg::HEX_INVALID) begin
            expect_out({hi[3:0], lo[3:0]}, l, 1'b0);
          end else begin
            expect_out(8'h00, 1'b1, 1'b1);
            if (!l) skipping = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch in %s: expected %0h, got %0h (cycle %0d)",
             what, exp_v, got_v, cycle_count);
    mismatches++;
  endtask

  // prediction on each accepted input transfer, checking on each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wen) begin
        codec_dir = cfg_wdata;
        held_cnt  = 2'd0;
        held_chr  = 8'h00;
        skipping  = 1'b0;
      end
      if (s_tvalid && s_tready) predict_conversion(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          report_mismatch("unexpected transfer, data", 0, 32'(m_tdata));
        end else begin
          oldest = expected_out.pop_front();
          if (m_tdata !== oldest.data)
            report_mismatch("m_tdata", 32'(oldest.data), 32'(m_tdata));
          if (m_tlast !== oldest.last)
            report_mismatch("m_tlast", 32'(oldest.last), 32'(m_tlast));
          if (m_tuser !== oldest.err)
            report_mismatch("m_tuser", 32'(oldest.err), 32'(m_tuser));
        end
      end
    end
  end

  always @(posedge clk) begin
    case (ready_mode)
      READY_ALWAYS:  m_tready <= 1'b1;
      READY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
      READY_PATTERN: m_tready <= ((cycle_count % 13) < 9);
      default:       m_tready <= ($urandom_range(0, 9) > 6);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (burst_left == 0) begin
      if (sender_bursty) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    cfg_wen   <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic [7:0] random_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return fupc_pkg::CHAR_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? fupc_pkg::CHAR_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
  endfunction

  task automatic send_encode_string();
    logic [7:0] text[$];
    int n;
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1:    text = {text, fupc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25))};
        2:       text = {text, fupc_pkg::CHAR_SPACE};
        3:       text = {text, fupc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))};
        default: text = {text, 8'($urandom_range(0, 255))};
      endcase
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_decode_string();
    logic [7:0] text[$];
    int n;
    logic noise;
    n = $urandom_range(1, 6);
    noise = ($urandom_range(0, 9) == 0);
    repeat (n) begin
      if (noise) begin
        text = {text, ($urandom_range(0, 2) == 0) ? fupc_pkg::CHAR_PCT
                                                  : 8'($urandom_range(0, 255))};
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            text = {text, fupc_pkg::CHAR_PCT, random_hex_char(), random_hex_char()};
          end
          4: text = {text, fupc_pkg::CHAR_PLUS};
          5: begin
            text = {text, fupc_pkg::CHAR_PCT, 8'($urandom_range(0, 255)),
                    random_hex_char()};
          end
          6: text = {text, fupc_pkg::CHAR_PCT};
          default: text = {text, 8'($urandom_range(0, 255))};
        endcase
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic test_encode_directed();
    write_direction(DIR_ENCODE);
    sender_bursty = 1'b1;
    ready_mode = READY_RANDOM;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(CH_LOWER_A, 1'b0);
    send_byte(CH_DASH, 1'b0);
    send_byte(CH_TILDE, 1'b0);
    send_byte(fupc_pkg::CHAR_SPACE, 1'b0);
    send_byte(8'h2F, 1'b0);
    send_byte(fupc_pkg::CHAR_PCT, 1'b1);
    settle();
  endtask

  task automatic test_decode_directed();
    write_direction(DIR_DECODE);
    ready_mode = READY_PATTERN;
    send_byte(fupc_pkg::CHAR_PLUS, 1'b0);
    // lowercase escape
    send_byte(fupc_pkg::CHAR_PCT, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h61, 1'b1);
    // bad pair, rest of string dropped
    send_byte(fupc_pkg::CHAR_PCT, 1'b0);
    send_byte(8'h47, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'h78, 1'b1);
    // short escapes
    send_byte(fupc_pkg::CHAR_PCT, 1'b1);
    send_byte(fupc_pkg::CHAR_PCT, 1'b0);
    send_byte(fupc_pkg::CHAR_PLUS, 1'b1);
    // bad pair on the last byte
    send_byte(fupc_pkg::CHAR_PCT, 1'b0);
    send_byte(fupc_pkg::CHAR_ZERO, 1'b0);
    send_byte(8'h21, 1'b1);
    settle();
  endtask

  task automatic test_config_abandons_escape();
    send_byte(fupc_pkg::CHAR_PCT, 1'b0);
    send_byte(8'h34, 1'b0);
    settle();
    write_direction(DIR_DECODE);
    send_byte(fupc_pkg::CHAR_PLUS, 1'b1);
    settle();
  endtask

  task automatic test_random_strings(input logic d, input logic bursty,
                                     input ready_mode_t mode, input int count);
    int start;
    logic paused;
    settle();
    write_direction(d);
    sender_bursty = bursty;
    ready_mode = mode;
    start = useful_items;
    paused = 1'b0;
    while (useful_items - start < count) begin
      if (d == DIR_DECODE) send_decode_string();
      else send_encode_string();
      if (!paused && useful_items - start >= count / 2) begin
        paused = 1'b1;
        settle();
      end
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_config_abandons_escape();
    test_random_strings(DIR_ENCODE, 1'b1, READY_RANDOM, 50);
    test_random_strings(DIR_DECODE, 1'b1, READY_PATTERN, 70);
    test_random_strings(DIR_ENCODE, 1'b0, READY_ALWAYS, 45);
    test_random_strings(DIR_DECODE, 1'b0, READY_ALWAYS, 50);
    test_random_strings(DIR_DECODE, 1'b1, READY_SLOW, 40);
    test_random_strings(DIR_ENCODE, 1'b1, READY_SLOW, 45);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/fupc_pkg.sv
hdl/fupc_front.sv
hdl/fupc_queue.sv
hdl/fupc_back.sv
hdl/form_url_percent_codec_unit.sv
verif/tb_form_url_percent_codec_unit.sv
